/* rtl/core/sop_pkg.sv */
package sop_pkg;

  localparam int MAX_SLABS = 16;
  localparam int MAX_SLOTS = 512;

  localparam int SLAB_W   = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
  localparam int SLOT_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int ADDR_W   = SLAB_W + SLOT_W;
  localparam int USE_W    = $clog2(MAX_SLABS + 1);
  localparam int HANDLE_W = 13;
  localparam int COUNT_W  = 10;
  localparam int OPS_W    = 10;
  localparam int LIM_W    = 5;
  localparam int STAT_W   = 2;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 1;

  localparam logic [0:0] CMD_ALLOC = 1'b0;
  localparam logic [0:0] CMD_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_OBJECTS_PER_SLAB = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SLAB_LIMIT       = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOM     = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

  localparam logic [OPS_W-1:0] OPS_RESET   = OPS_W'(512);
  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(16);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INIT,
    S_POP,
    S_POPW,
    S_FREE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [SLOT_W-1:0] data;
  } link_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } link_rd_t;

endpackage

/* rtl/core/slab_object_pool_top.sv */
// free: a valid handle goes through S_FREE to S_RESP; an invalid handle goes straight to S_RESP
// allocate from an existing slab: S_SCAN over slabs newest first, then S_POP, S_POPW, S_RESP
// allocate that adds a slab: S_SCAN over all slabs in use, then objects_per_slab (at most 512)
//   next-slot link writes in S_INIT (one per cycle), then as above; out of memory: S_SCAN, S_RESP
// one item at a time; the next input is taken while the last result waits for transfer
// synchronous active-low reset clears slab count, free counts and handshake state
module slab_object_pool_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_command,
  input  logic [sop_pkg::HANDLE_W-1:0]    in_object_handle,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sop_pkg::HANDLE_W-1:0]    out_granted_handle,
  output logic [sop_pkg::STAT_W-1:0]      out_status,
  input  logic                            cfg_we,
  input  logic [sop_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sop_pkg::CFG_W-1:0]       cfg_wdata
);
  import sop_pkg::*;

  state_t state_r, state_nxt;

  logic [OPS_W-1:0]   objects_per_slab_r;
  logic [LIM_W-1:0]   slab_limit_r;

  logic [SLOT_W-1:0]  head_r  [MAX_SLABS];
  logic [COUNT_W-1:0] count_r [MAX_SLABS];
  logic [COUNT_W-1:0] objcnt_r [MAX_SLABS];
  logic [USE_W-1:0]   in_use_r, in_use_nxt;

  logic [SLAB_W-1:0]   sel_r, sel_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [USE_W-1:0]    idx_r, idx_nxt;
  logic [HANDLE_W-1:0] res_handle_r, res_handle_nxt;
  logic [STAT_W-1:0]   res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;

  logic               head_we, cnt_we, obj_we;
  logic [SLOT_W-1:0]  head_wd;
  logic [COUNT_W-1:0] cnt_wd;

  link_wr_t          link_wr;
  link_rd_t          link_rd;
  logic [SLOT_W-1:0] link_rdata;

  logic                       in_xfer;
  logic [COUNT_W-1:0]         eff_slots;
  logic [LIM_W-1:0]           eff_limit;
  logic [HANDLE_W-SLOT_W-1:0] f_slab;
  logic [SLOT_W-1:0]          f_slot;
  logic                       free_ok;
  logic [SLAB_W-1:0]          scan_k;
  logic                       scan_end, scan_hit, grow_ok;
  logic [COUNT_W-1:0]         init_next;
  logic                       init_last;
  logic                       out_free;

  sop_link_ram u_link_ram (
    .clk     (clk),
    .wr      (link_wr),
    .rd      (link_rd),
    .rd_data (link_rdata)
  );

  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign eff_slots = (objects_per_slab_r > OPS_W'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS)
                                                               : COUNT_W'(objects_per_slab_r);
  assign eff_limit = (slab_limit_r > LIM_W'(MAX_SLABS)) ? LIM_W'(MAX_SLABS) : slab_limit_r;

  assign f_slab  = in_object_handle[HANDLE_W-1:SLOT_W];
  assign f_slot  = in_object_handle[SLOT_W-1:0];
  assign free_ok = (HANDLE_W'(f_slab) < HANDLE_W'(in_use_r)) &&
                   (COUNT_W'(f_slot) < objcnt_r[f_slab[SLAB_W-1:0]]);

  assign scan_end = (idx_r == '0);
  assign scan_k   = SLAB_W'(idx_r - USE_W'(1));
  assign scan_hit = !scan_end && (count_r[scan_k] != '0);
  assign grow_ok  = (eff_slots != '0) && (in_use_r < USE_W'(eff_limit)) &&
                    (in_use_r < USE_W'(MAX_SLABS));

  assign init_next = COUNT_W'(slot_r) + COUNT_W'(1);
  assign init_last = (init_next >= eff_slots);

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_command == CMD_FREE) begin
            state_nxt = free_ok ? S_FREE : S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = grow_ok ? S_INIT : S_RESP;
        end else if (scan_hit) begin
          state_nxt = S_POP;
        end
      end
      S_INIT: begin
        if (init_last) begin
          state_nxt = S_POP;
        end
      end
      S_POP:  state_nxt = S_POPW;
      S_POPW: state_nxt = S_RESP;
      S_FREE: state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    sel_nxt        = sel_r;
    slot_nxt       = slot_r;
    idx_nxt        = idx_r;
    res_handle_nxt = res_handle_r;
    res_status_nxt = res_status_r;
    in_use_nxt     = in_use_r;
    out_handle_nxt = out_handle_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    head_we        = 1'b0;
    head_wd        = '0;
    cnt_we         = 1'b0;
    cnt_wd         = '0;
    obj_we         = 1'b0;
    link_wr        = '0;
    link_rd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_handle_nxt = '0;
          if (in_command == CMD_FREE) begin
            sel_nxt        = f_slab[SLAB_W-1:0];
            slot_nxt       = f_slot;
            res_status_nxt = free_ok ? ST_OK : ST_INVALID;
          end else begin
            idx_nxt        = in_use_r;
            res_status_nxt = ST_OOM;
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          sel_nxt  = in_use_r[SLAB_W-1:0];
          slot_nxt = '0;
        end else if (scan_hit) begin
          sel_nxt = scan_k;
        end else begin
          idx_nxt = idx_r - USE_W'(1);
        end
      end
      S_INIT: begin
        link_wr.we   = 1'b1;
        link_wr.addr = {sel_r, slot_r};
        link_wr.data = init_last ? '0 : init_next[SLOT_W-1:0];
        if (init_last) begin
          head_we    = 1'b1;
          head_wd    = '0;
          cnt_we     = 1'b1;
          cnt_wd     = eff_slots;
          obj_we     = 1'b1;
          in_use_nxt = in_use_r + USE_W'(1);
        end else begin
          slot_nxt = init_next[SLOT_W-1:0];
        end
      end
      S_POP: begin
        link_rd.re     = 1'b1;
        link_rd.addr   = {sel_r, head_r[sel_r]};
        res_handle_nxt = HANDLE_W'({sel_r, head_r[sel_r]});
        res_status_nxt = ST_OK;
        cnt_we         = 1'b1;
        cnt_wd         = count_r[sel_r] - COUNT_W'(1);
      end
      S_POPW: begin
        head_we = 1'b1;
        head_wd = link_rdata;
      end
      S_FREE: begin
        link_wr.we   = 1'b1;
        link_wr.addr = {sel_r, slot_r};
        link_wr.data = head_r[sel_r];
        head_we      = 1'b1;
        head_wd      = slot_r;
        cnt_we       = 1'b1;
        cnt_wd       = count_r[sel_r] + COUNT_W'(1);
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_handle_nxt = res_handle_r;
          out_status_nxt = res_status_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      out_valid_r        <= 1'b0;
      in_use_r           <= '0;
      objects_per_slab_r <= OPS_RESET;
      slab_limit_r       <= LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      in_use_r    <= in_use_nxt;
      if (cfg_we && cfg_index == REG_OBJECTS_PER_SLAB) begin
        objects_per_slab_r <= cfg_wdata[OPS_W-1:0];
      end
      if (cfg_we && cfg_index == REG_SLAB_LIMIT) begin
        slab_limit_r <= cfg_wdata[LIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SLABS; i++) begin
        count_r[i] <= '0;
      end
    end else if (cnt_we) begin
      count_r[sel_r] <= cnt_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_r[sel_r] <= head_wd;
    end
    if (obj_we) begin
      objcnt_r[sel_r] <= eff_slots;
    end
    sel_r        <= sel_nxt;
    slot_r       <= slot_nxt;
    idx_r        <= idx_nxt;
    res_handle_r <= res_handle_nxt;
    res_status_r <= res_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_granted_handle = out_handle_r;
  assign out_status         = out_status_r;

  a_in_use_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_use_r <= USE_W'(MAX_SLABS))
    else $error("slab count above maximum");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> (count_r[sel_r] != '0))
    else $error("pop from empty slab");

  a_grow_only_init: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && in_use_r != $past(in_use_r)) |-> ($past(state_r) == S_INIT))
    else $error("slab count changed outside link init");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != S_IDLE))
    else $error("transfer taken without starting work");

endmodule

/* rtl/core/sop_link_ram.sv */
module sop_link_ram (
  input  logic                      clk,
  input  sop_pkg::link_wr_t         wr,
  input  sop_pkg::link_rd_t         rd,
  output logic [sop_pkg::SLOT_W-1:0] rd_data
);
  import sop_pkg::*;

  logic [SLOT_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
  import sop_pkg::*;

  localparam int STUCK_LIMIT = 20000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic                cmd;
    logic [HANDLE_W-1:0] handle;
  } pool_req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [STAT_W-1:0]   status;
  } pool_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_command = CMD_ALLOC;
  logic [HANDLE_W-1:0]  in_object_handle = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [HANDLE_W-1:0]  out_granted_handle;
  logic [STAT_W-1:0]    out_status;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_OBJECTS_PER_SLAB;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  slab_object_pool_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_object_handle   (in_object_handle),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_granted_handle (out_granted_handle),
    .out_status         (out_status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // pool shadow
  logic [SLOT_W-1:0]  link_mem [MAX_SLABS*MAX_SLOTS];
  logic [SLOT_W-1:0]  head_slot [MAX_SLABS];
  logic [COUNT_W-1:0] free_cnt [MAX_SLABS];
  logic [COUNT_W-1:0] built_slots [MAX_SLABS];
  int                 slabs_used;
  int                 cur_ops;
  int                 cur_lim;
  logic [HANDLE_W-1:0] live_handles [$];

  pool_req_t    pending_reqs [$];
  pool_result_t expected_grants [$];

  int mismatches = 0;
  int req_count = 0;
  int grant_count = 0;
  int oom_count = 0;
  int rejected_frees = 0;
  int stuck_cycles = 0;

  int        burst_left = 0;
  int        gap_left = 0;
  int        rx_mode = 0;
  int        rx_mode_left = 0;
  pool_req_t next_req;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  function automatic logic [HANDLE_W-1:0] pop_slot(input int k);
    logic [SLOT_W-1:0] slot;
    slot = head_slot[k];
    head_slot[k] = link_mem[k*MAX_SLOTS + slot];
    free_cnt[k] = free_cnt[k] - 1'b1;
    return HANDLE_W'(k*MAX_SLOTS + slot);
  endfunction

  function automatic void predict_pool_result(input logic cmd, input logic [HANDLE_W-1:0] h);
    pool_result_t r;
    int           n, lim_eff, k, slab, slot;
    logic         found;
    r.handle = '0;
    r.status = ST_OOM;
    found = 1'b0;
    req_count++;
    if (cmd == CMD_ALLOC) begin
      for (k = slabs_used - 1; k >= 0 && !found; k--) begin
        if (free_cnt[k] != 0) begin
          r.handle = pop_slot(k);
          r.status = ST_OK;
          found = 1'b1;
        end
      end
      if (!found) begin
        n = (cur_ops > MAX_SLOTS) ? MAX_SLOTS : cur_ops;
        lim_eff = (cur_lim > MAX_SLABS) ? MAX_SLABS : cur_lim;
        if (n != 0 && slabs_used < lim_eff) begin
          for (k = 0; k < n; k++)
            link_mem[slabs_used*MAX_SLOTS + k] = SLOT_W'((k + 1 < n) ? k + 1 : 0);
          head_slot[slabs_used] = '0;
          free_cnt[slabs_used] = COUNT_W'(n);
          built_slots[slabs_used] = COUNT_W'(n);
          slabs_used++;
          r.handle = pop_slot(slabs_used - 1);
          r.status = ST_OK;
        end
      end
      if (r.status == ST_OK) begin
        live_handles.push_back(r.handle);
        grant_count++;
      end else begin
        oom_count++;
      end
    end else begin
      slab = int'(h) / MAX_SLOTS;
      slot = int'(h) % MAX_SLOTS;
      if (slab >= slabs_used || slot >= built_slots[slab]) begin
        r.status = ST_INVALID;
        rejected_frees++;
      end else begin
        link_mem[slab*MAX_SLOTS + slot] = head_slot[slab];
        head_slot[slab] = SLOT_W'(slot);
        free_cnt[slab] = free_cnt[slab] + 1'b1;
        r.status = ST_OK;
        for (k = 0; k < live_handles.size(); k++) begin
          if (live_handles[k] == h) begin
            live_handles.delete(k);
            break;
          end
        end
      end
    end
    expected_grants.push_back(r);
  endfunction

  function automatic void check_grant(input logic [HANDLE_W-1:0] h, input logic [STAT_W-1:0] st);
    pool_result_t e;
    if (expected_grants.size() == 0) begin
      if (mismatches < 10)
        $display("[%0t] unexpected result handle=%0d status=%0d", $time, h, st);
      mismatches++;
    end else begin
      e = expected_grants.pop_front();
      if (h !== e.handle || st !== e.status) begin
        if (mismatches < 10)
          $display("[%0t] mismatch: expected handle=%0d status=%0d, got handle=%0d status=%0d",
                   $time, e.handle, e.status, h, st);
        mismatches++;
      end
    end
  endfunction

  function automatic void push_req(input logic cmd, input logic [HANDLE_W-1:0] h);
    pool_req_t q;
    q.cmd = cmd;
    q.handle = h;
    pending_reqs.push_back(q);
  endfunction

  // driver: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_fire) predict_pool_result(in_command, in_object_handle);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          next_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_command <= next_req.cmd;
          in_object_handle <= next_req.handle;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_mode_left <= 0;
    end else begin
      if (out_fire) check_grant(out_granted_handle, out_status);
      if (rx_mode_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_mode_left <= $urandom_range(50, 300);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 1);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (in_fire || out_fire || cfg_we) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_grants.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_cfg(input int ops, input int lim);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_OBJECTS_PER_SLAB;
    cfg_wdata <= CFG_W'(ops);
    cur_ops = ops & 32'h3ff;
    @(posedge clk);
    cfg_index <= REG_SLAB_LIMIT;
    cfg_wdata <= CFG_W'(lim);
    cur_lim = lim & 32'h1f;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_batch(input int n);
    logic [HANDLE_W-1:0] picks [$];
    int                  i, r, idx, s;
    pool_req_t           q;
    wait_drained();
    picks = live_handles;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      q.handle = HANDLE_W'($urandom);
      q.cmd = CMD_FREE;
      if (r < 50 || (r < 80 && picks.size() == 0)) begin
        q.cmd = CMD_ALLOC;
      end else if (r < 80) begin
        idx = $urandom_range(0, picks.size() - 1);
        q.handle = picks[idx];
        if ($urandom_range(0, 4) != 0) picks.delete(idx);
      end else if (r < 90 && slabs_used > 0) begin
        s = $urandom_range(0, slabs_used - 1);
        if (built_slots[s] < MAX_SLOTS)
          q.handle = HANDLE_W'(s*MAX_SLOTS + $urandom_range(built_slots[s], MAX_SLOTS - 1));
      end
      pending_reqs.push_back(q);
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int ph, sent, n, ops, lim, k, total_free, s;
    for (k = 0; k < MAX_SLABS*MAX_SLOTS; k++) link_mem[k] = '0;
    for (k = 0; k < MAX_SLABS; k++) begin
      head_slot[k] = '0;
      free_cnt[k] = '0;
      built_slots[k] = '0;
    end
    slabs_used = 0;
    cur_ops = OPS_RESET;
    cur_lim = LIMIT_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // zero slots per slab, handle extremes on an empty pool
    write_cfg(0, 31);
    push_req(CMD_ALLOC, '0);
    push_req(CMD_FREE, '0);
    push_req(CMD_FREE, '1);
    // zero slab limit
    write_cfg(5, 0);
    push_req(CMD_ALLOC, '1);
    // single-slot slab: limit hit, bad frees, double free
    write_cfg(1, 1);
    push_req(CMD_ALLOC, '0);
    push_req(CMD_ALLOC, '0);
    push_req(CMD_FREE, HANDLE_W'(1));
    push_req(CMD_FREE, HANDLE_W'(MAX_SLOTS));
    push_req(CMD_FREE, '0);
    push_req(CMD_FREE, '0);
    push_req(CMD_ALLOC, '0);
    push_req(CMD_ALLOC, '0);
    push_req(CMD_ALLOC, '0);
    push_req(CMD_FREE, HANDLE_W'(1));
    // second slab, last link wraps, lifo reuse, old slab keeps its size
    write_cfg(3, 2);
    for (k = 0; k < 4; k++) push_req(CMD_ALLOC, HANDLE_W'($urandom));
    push_req(CMD_FREE, HANDLE_W'(MAX_SLOTS + 1));
    push_req(CMD_FREE, HANDLE_W'(MAX_SLOTS));
    push_req(CMD_ALLOC, '0);
    push_req(CMD_ALLOC, '0);
    push_req(CMD_FREE, HANDLE_W'(1));

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      ops = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
      lim = slabs_used + $urandom_range(0, 2);
      if (lim > 14) lim = 14;
      write_cfg(ops, lim);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        n = $urandom_range(1, 40);
        random_batch(n);
        sent += n;
      end
    end

    // oversized registers: fill every slab, then build a full-size one
    write_cfg(1023, 31);
    total_free = 0;
    for (k = 0; k < slabs_used; k++) total_free += free_cnt[k];
    for (k = 0; k <= total_free; k++) push_req(CMD_ALLOC, HANDLE_W'($urandom));
    wait_drained();
    s = slabs_used - 1;
    push_req(CMD_FREE, HANDLE_W'(s*MAX_SLOTS + MAX_SLOTS - 1));
    push_req(CMD_ALLOC, '0);
    push_req(CMD_ALLOC, '0);
    push_req(CMD_FREE, '1);

    wait_drained();
    repeat (50) @(posedge clk);
    $display("covered %0d requests: %0d grants, %0d out of memory, %0d rejected frees",
             req_count, grant_count, oom_count, rejected_frees);
    $display("slabs built: %0d, mismatches: %0d", slabs_used, mismatches);
    if (mismatches == 0 && expected_grants.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/sop_pkg.sv
rtl/core/sop_link_ram.sv
rtl/core/slab_object_pool_top.sv
bench/tb.sv
